### sv/pngup_pkg.sv
`timescale 1ns / 1ps

package pngup_pkg;

  localparam int MAX_COLUMNS = 4096;
  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W = COL_W + 1;

  localparam logic [3:0] UP_MODE = 4'd12;

  // configuration register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic             zero;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [7:0]       data;
  } wr_req_t;

endpackage

### sv/pngup_row_buf.sv
`timescale 1ns / 1ps

module pngup_row_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  pngup_pkg::rd_req_t rd,
  input  pngup_pkg::wr_req_t wr,
  output logic [7:0]         above
);

  logic [7:0]                  mem [pngup_pkg::MAX_COLUMNS];
  logic [7:0]                  rdata_r;
  logic                        zero_r;
  logic [pngup_pkg::CNT_W-1:0] fill_r;
  logic [pngup_pkg::CNT_W-1:0] fill_nxt;

  // every row writes columns from zero upward, so written entries form a prefix
  always_comb begin
    fill_nxt = fill_r;
    if (wr.en && ({1'b0, wr.addr} >= fill_r)) begin
      fill_nxt = {1'b0, wr.addr} + pngup_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata_r <= mem[rd.addr];
      zero_r  <= rd.zero || ({1'b0, rd.addr} >= fill_r);
    end
  end

  assign above = zero_r ? 8'd0 : rdata_r;

endmodule

### sv/png_up_predictor_undo_top.sv
`timescale 1ns / 1ps

// PNG Up-predictor undo on an inflated byte stream. Takes one input item per
// clock and sustains one per clock with no stalls of its own; a result passes
// through stage one and then the output register. The previous-row memory
// (4096 x 8) has a registered read, and stage one adds and writes back. With
// predictor_mode 12 the filter byte of each row is dropped and each data byte
// gets the byte above it added mod 256; any other mode passes bytes through.
// A stream ends with in_tlast; the next stream sees an all-zero previous row in
// its first row. Entries never written since reset read as zero (tracked by a
// fill count, no clearing pass). out_tlast marks stream end; out_tuser low
// means a stream-end marker with no data byte. Configuration may be written
// only while no item is in flight.

module png_up_predictor_undo_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] row_end, [9] tail_incomplete
  output logic        out_tuser,  // has_data
  output logic        out_tlast,  // stream_end
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_wdata
);

  localparam int CW = pngup_pkg::COL_W;
  localparam int NW = pngup_pkg::CNT_W;

  logic [3:0]    mode_r;
  logic [NW-1:0] cols_r;
  logic [NW-1:0] eff_cols;

  logic [NW-1:0] col_cnt_r, col_cnt_nxt;
  logic          first_row_r, first_row_nxt;

  logic          in_acc;
  logic          up_mode, is_filter, is_data, ends_row;
  logic [NW-1:0] col_m1;
  logic [CW-1:0] col_idx;

  logic          s1_valid_r, s1_res_r, s1_data_r, s1_has_data_r;
  logic          s1_row_end_r, s1_last_r, s1_tail_r;
  logic [7:0]    s1_byte_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_adv;
  logic [7:0]    s1_val;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_has_data_r, out_row_end_r, out_last_r, out_tail_r;

  pngup_pkg::rd_req_t rd;
  pngup_pkg::wr_req_t wr;
  logic [7:0]         above;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 4'd1;
      cols_r <= NW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        pngup_pkg::REG_MODE: mode_r <= cfg_wdata[3:0];
        pngup_pkg::REG_COLS: cols_r <= cfg_wdata[NW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_r == '0) begin
      eff_cols = NW'(1);
    end else if (cols_r > NW'(pngup_pkg::MAX_COLUMNS)) begin
      eff_cols = NW'(pngup_pkg::MAX_COLUMNS);
    end else begin
      eff_cols = cols_r;
    end
  end

  assign s1_adv    = s1_valid_r && (!s1_res_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    up_mode   = (mode_r == pngup_pkg::UP_MODE);
    is_filter = up_mode && (col_cnt_r == '0);
    is_data   = up_mode && (col_cnt_r != '0);
    col_m1    = col_cnt_r - NW'(1);
    if (col_m1 >= NW'(pngup_pkg::MAX_COLUMNS)) begin
      col_idx = CW'(pngup_pkg::MAX_COLUMNS - 1);
    end else begin
      col_idx = col_m1[CW-1:0];
    end
    ends_row = (col_cnt_r >= eff_cols);

    col_cnt_nxt   = col_cnt_r;
    first_row_nxt = first_row_r;
    if (in_acc) begin
      if (is_filter) begin
        col_cnt_nxt = NW'(1);
      end else if (is_data) begin
        if (ends_row) begin
          col_cnt_nxt   = '0;
          first_row_nxt = 1'b0;
        end else begin
          col_cnt_nxt = col_cnt_r + NW'(1);
        end
      end
      if (in_tlast) begin
        col_cnt_nxt   = '0;
        first_row_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      first_row_r <= 1'b1;
    end else begin
      col_cnt_r   <= col_cnt_nxt;
      first_row_r <= first_row_nxt;
    end
  end

  // same-column accesses are a whole row apart, so the write lands before the next read
  assign rd.en   = in_acc && is_data;
  assign rd.addr = col_idx;
  assign rd.zero = first_row_r;

  assign s1_val  = s1_data_r ? (s1_byte_r + above) : s1_byte_r;

  assign wr.en   = s1_adv && s1_data_r;
  assign wr.addr = s1_col_r;
  assign wr.data = s1_val;

  pngup_row_buf u_row_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .rd    (rd),
    .wr    (wr),
    .above (above)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r      <= !is_filter || in_tlast;
      s1_data_r     <= is_data;
      s1_has_data_r <= !is_filter;
      s1_byte_r     <= is_filter ? 8'd0 : in_tdata;
      s1_col_r      <= col_idx;
      s1_row_end_r  <= is_data && ends_row;
      s1_last_r     <= in_tlast;
      s1_tail_r     <= up_mode && in_tlast && !(is_data && ends_row);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_res_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res_r) begin
      out_byte_r     <= s1_val;
      out_has_data_r <= s1_has_data_r;
      out_row_end_r  <= s1_row_end_r;
      out_last_r     <= s1_last_r;
      out_tail_r     <= s1_tail_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_tail_r, out_row_end_r, out_byte_r};
  assign out_tuser  = out_has_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_acc)
    else $error("item accepted while stage one is stalled");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (col_cnt_r == '0 && first_row_r))
    else $error("stream end did not restart row state");

  a_marker_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_data_r) |-> (out_last_r && out_tail_r && out_byte_r == 8'd0))
    else $error("data-less result that is not a stream-end marker");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_cnt_r <= NW'(pngup_pkg::MAX_COLUMNS))
    else $error("column count beyond row buffer depth");
`endif

endmodule
